FILE: rtl/poc_pkg.sv
// ----------------------------------------------------------------------------
// poc_pkg
// Shared types, codes and constants of the priority weighted object cache.
// ----------------------------------------------------------------------------
`default_nettype none

package poc_pkg;

  // Default configuration
  localparam int ENTRIES_DEF     = 32;
  localparam int AGE_CAP_DEF     = 65535;
  localparam int NORMAL_PRI_DEF  = 2;

  // Fixed widths
  localparam int BYTES_W  = 29;
  localparam int SIZE_W   = 24;
  localparam int AGE_W    = 23;
  localparam int SCORE_W  = 34;
  localparam int NEED_W   = 32;

  localparam logic [BYTES_W-1:0] BYTES_MAX   = '1;
  localparam logic [BYTES_W-1:0] LIMIT_RESET = 29'd1048576;
  localparam logic [2:0]         PRI_ALL     = 3'd7;
  localparam logic               REG_LIMIT   = 1'b0;

  // Command codes
  localparam logic [2:0] CMD_FETCH    = 3'd0;
  localparam logic [2:0] CMD_PREFETCH = 3'd1;
  localparam logic [2:0] CMD_FIND     = 3'd2;
  localparam logic [2:0] CMD_SETPRI   = 3'd3;
  localparam logic [2:0] CMD_RELEASE  = 3'd4;
  localparam logic [2:0] CMD_TRIM     = 3'd5;

  // Status codes
  localparam logic [2:0] ST_HIT         = 3'd0;
  localparam logic [2:0] ST_LOADED      = 3'd1;
  localparam logic [2:0] ST_NOT_PRESENT = 3'd2;
  localparam logic [2:0] ST_NO_ROOM     = 3'd3;
  localparam logic [2:0] ST_LOAD_ERR    = 3'd4;
  localparam logic [2:0] ST_NOT_CACHED  = 3'd5;
  localparam logic [2:0] ST_DONE        = 3'd6;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EVICT  = 1'b1;

  typedef struct packed {
    logic [31:0] type_tag;
    logic [31:0] chunk_number;
    logic [3:0]  reader_id;
  } key_t;

  // Write command broadcast to the cells
  typedef struct packed {
    logic              ins;
    logic              set_refs;
    logic              set_pri;
    logic              set_stamp;
    logic              clr;
    key_t              key;
    logic [SIZE_W-1:0] size;
    logic [7:0]        refs;
    logic [2:0]        pri;
    logic [31:0]       stamp;
  } cell_op_t;

  // Victim search controls broadcast to the cells
  typedef struct packed {
    logic signed [NEED_W-1:0] need;
    logic [31:0]              clock;
    logic [2:0]               pri_last;
  } scan_ctl_t;

  // Best candidate handed down the chain
  typedef struct packed {
    logic                      valid;
    logic [2:0]                pri;
    logic signed [SCORE_W-1:0] score;
    key_t                      key;
    logic [SIZE_W-1:0]         size;
  } token_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_SCAN,
    S_EVICT,
    S_PF_INS,
    S_EV_ADDR,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/poc_cell.sv
// ----------------------------------------------------------------------------
// poc_cell
// One directory entry: key match, score register and one stage of the
// victim search chain.
// ----------------------------------------------------------------------------
`default_nettype none

module poc_cell
  import poc_pkg::*;
#(
  parameter int AGE_CAP = AGE_CAP_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                sel,
  input  cell_op_t           op,
  input  key_t               look_key,
  input  scan_ctl_t          scan,
  input  token_t             tok_in,
  output token_t             tok_out,
  output logic               hit,
  output logic               valid,
  output logic [7:0]         refs,
  output logic [2:0]         pri,
  output logic [SIZE_W-1:0]  size
);

  localparam logic [31:0] CAP = 32'(AGE_CAP);

  key_t                      key_r;
  logic [31:0]               stamp;
  logic signed [SCORE_W-1:0] score;
  logic signed [SCORE_W-1:0] score_next;
  token_t                    tok;
  logic                      better;
  logic                      eligible;

  // score = 2|d| - d - 256*min(age, cap), d = size - need
  always_comb begin
    logic signed [NEED_W-1:0] d;
    logic [NEED_W-1:0]        mag;
    logic [32:0]              pos;
    logic [31:0]              age;
    logic [AGE_W-1:0]         agec;
    d    = $signed({8'b0, size}) - scan.need;
    mag  = d[NEED_W-1] ? NEED_W'(-d) : NEED_W'(d);
    pos  = d[NEED_W-1] ? ({1'b0, mag} + {mag, 1'b0}) : {1'b0, mag};
    age  = scan.clock - stamp;
    agec = (age > CAP) ? AGE_W'(CAP) : age[AGE_W-1:0];
    score_next = $signed({1'b0, pos}) - $signed({3'b0, agec, 8'b0});
  end

  // chain stage compare
  always_comb begin
    eligible = valid && (refs == 8'd0) && (pri <= scan.pri_last);
    better   = !tok_in.valid || (pri < tok_in.pri) ||
               ((pri == tok_in.pri) &&
                ((score < $signed(tok_in.score)) ||
                 ((score == $signed(tok_in.score)) && (key_r < tok_in.key))));
  end

  assign hit     = valid && (key_r == look_key);
  assign tok_out = tok;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      tok   <= '0;
    end else begin
      if (sel && op.ins) begin
        valid <= 1'b1;
      end else if (op.clr && valid && (key_r == op.key)) begin
        valid <= 1'b0;
      end
      if (eligible && better) begin
        tok <= '{valid: 1'b1, pri: pri, score: score, key: key_r, size: size};
      end else begin
        tok <= tok_in;
      end
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    score <= score_next;
    if (sel && op.ins) begin
      key_r <= op.key;
      size  <= op.size;
      pri   <= op.pri;
      refs  <= op.refs;
      stamp <= op.stamp;
    end else begin
      if (sel && op.set_refs) begin
        refs <= op.refs;
      end
      if (sel && op.set_pri) begin
        pri <= op.pri;
      end
      if (sel && op.set_stamp) begin
        stamp <= op.stamp;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/priority_weighted_object_cache.sv
// ----------------------------------------------------------------------------
// priority_weighted_object_cache
// Object cache directory with priority and score driven eviction.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the in_valid/in_ready channel, one transfer each.
//   Every command yields zero or more eviction notices (kind 1) and then
//   one final status item (kind 0, last 1) on the out_valid/out_ready
//   channel. byte_limit is written through the APB port while idle, a
//   rule for the user that the block itself does not enforce. Each
//   command is registered on its transfer, then passes S_LOOK, S_DECIDE
//   and S_FIN, which presents its final status; a prefetch that inserts
//   also passes S_PF_INS. Each eviction of a purge follows a victim
//   search that walks the cell chain one cell per cycle; an eviction of
//   the addressed entry passes S_EV_ADDR. One command is processed at a time.
//   Reset empties the directory, clears the byte count and release clock
//   and restores byte_limit to 1048576.
//   A stalled receiver holds the block in its current emit step; the
//   pending result stays in the output register until transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_weighted_object_cache
  import poc_pkg::*;
#(
  parameter int ENTRIES         = ENTRIES_DEF,
  parameter int AGE_CAP         = AGE_CAP_DEF,
  parameter int NORMAL_PRIORITY = NORMAL_PRI_DEF
) (
  input  wire                clk,
  input  wire                rst,
  // command channel
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [2:0]         command,
  input  wire  [31:0]        type_tag,
  input  wire  [31:0]        chunk_number,
  input  wire  [3:0]         reader_id,
  input  wire                chunk_in_file,
  input  wire  [23:0]        object_size,
  input  wire                reader_ok,
  input  wire  [2:0]         priority_req,
  // result channel
  output logic               out_valid,
  input  wire                out_ready,
  output logic               kind,
  output logic [2:0]         status,
  output logic [31:0]        out_type_tag,
  output logic [31:0]        out_chunk_number,
  output logic [3:0]         out_reader_id,
  output logic [7:0]         ref_count,
  output logic [28:0]        bytes_in_use,
  output logic               last,
  // configuration
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [2:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 2);
  localparam logic [CW-1:0] CNT_END = CW'(ENTRIES + 1);
  localparam logic [2:0]    NORM_PRI = 3'(NORMAL_PRIORITY);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t                   state, state_next;
  logic [2:0]               cmd_q;
  key_t                     key_q;
  logic                     in_file_q;
  logic [SIZE_W-1:0]        size_in_q;
  logic                     ok_q;
  logic [2:0]               req_q;
  logic                     hit_q;
  logic [IW-1:0]            idx_q;
  logic [7:0]               refs_q;
  logic [2:0]               pri_q;
  logic [SIZE_W-1:0]        hsize_q;
  logic [2:0]               status_q, status_q_next;
  logic signed [NEED_W-1:0] need_q, need_q_next;
  logic [2:0]               pri_last_q, pri_last_q_next;
  logic [31:0]              clock_q, clock_q_next;
  logic [BYTES_W-1:0]       bytes_q, bytes_q_next;
  logic [BYTES_W-1:0]       limit_q;
  logic [CW-1:0]            cnt, cnt_next;
  logic [SIZE_W-1:0]        ev_size_q, ev_size_q_next;
  token_t                   vic_q, vic_q_next;

  // --------------------------------------------------------------------------
  // Cell chain
  // --------------------------------------------------------------------------
  cell_op_t                 op;
  logic [IW-1:0]            op_idx;
  scan_ctl_t                scan;
  token_t                   chain [ENTRIES+1];
  logic [ENTRIES-1:0]       c_hit;
  logic [ENTRIES-1:0]       c_valid;
  logic [7:0]               c_refs [ENTRIES];
  logic [2:0]               c_pri [ENTRIES];
  logic [SIZE_W-1:0]        c_size [ENTRIES];

  assign chain[0] = '0;
  assign scan     = '{need: need_q, clock: clock_q, pri_last: pri_last_q};

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    poc_cell #(
      .AGE_CAP (AGE_CAP)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .sel      (op_idx == IW'(k)),
      .op       (op),
      .look_key (key_q),
      .scan     (scan),
      .tok_in   (chain[k]),
      .tok_out  (chain[k+1]),
      .hit      (c_hit[k]),
      .valid    (c_valid[k]),
      .refs     (c_refs[k]),
      .pri      (c_pri[k]),
      .size     (c_size[k])
    );
  end

  // --------------------------------------------------------------------------
  // Lookup and free slot search
  // --------------------------------------------------------------------------
  logic              l_hit;
  logic [IW-1:0]     l_idx;
  logic [7:0]        l_refs;
  logic [2:0]        l_pri;
  logic [SIZE_W-1:0] l_size;
  logic              free_any;
  logic [IW-1:0]     free_idx;

  always_comb begin
    l_hit    = |c_hit;
    l_idx    = '0;
    l_refs   = '0;
    l_pri    = '0;
    l_size   = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      if (c_hit[k]) begin
        l_idx  = l_idx | IW'(k);
        l_refs = l_refs | c_refs[k];
        l_pri  = l_pri | c_pri[k];
        l_size = l_size | c_size[k];
      end
    end
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      if (!c_valid[k]) begin
        free_any = 1'b1;
        free_idx = IW'(k);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Arithmetic helpers
  // --------------------------------------------------------------------------
  logic [BYTES_W:0]   sum_ins;
  logic [BYTES_W-1:0] bytes_ins;
  logic               over_now;
  logic [7:0]         refs_inc;
  logic [2:0]         pf_pri;
  logic [BYTES_W-1:0] bytes_vic;
  logic [BYTES_W-1:0] bytes_addr;
  logic signed [NEED_W-1:0] need_left;

  always_comb begin
    sum_ins    = {1'b0, bytes_q} + (BYTES_W+1)'(size_in_q);
    bytes_ins  = sum_ins[BYTES_W] ? BYTES_MAX : sum_ins[BYTES_W-1:0];
    over_now   = bytes_q > limit_q;
    refs_inc   = (refs_q == 8'hFF) ? refs_q : refs_q + 8'd1;
    pf_pri     = (req_q > pri_q) ? req_q : pri_q;
    bytes_vic  = (bytes_q >= BYTES_W'(vic_q.size)) ? bytes_q - BYTES_W'(vic_q.size) : '0;
    bytes_addr = (bytes_q >= BYTES_W'(ev_size_q)) ? bytes_q - BYTES_W'(ev_size_q) : '0;
    need_left  = need_q - $signed(NEED_W'(vic_q.size));
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic               out_free;
  logic               emit;
  logic               e_kind;
  logic [2:0]         e_status;
  key_t               e_key;
  logic [7:0]         e_refs;
  logic [BYTES_W-1:0] e_bytes;
  logic               e_last;

  assign out_free = !out_valid || out_ready;

  // --------------------------------------------------------------------------
  // Sequencer: next state and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    state_next      = state;
    status_q_next   = status_q;
    need_q_next     = need_q;
    pri_last_q_next = pri_last_q;
    clock_q_next    = clock_q;
    bytes_q_next    = bytes_q;
    cnt_next        = cnt;
    ev_size_q_next  = ev_size_q;
    vic_q_next      = vic_q;
    op              = '0;
    op.key          = key_q;
    op_idx          = idx_q;
    emit            = 1'b0;
    e_kind          = KIND_STATUS;
    e_status        = ST_DONE;
    e_key           = key_q;
    e_refs          = 8'd0;
    e_bytes         = bytes_q;
    e_last          = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_LOOK;
        end
      end

      S_LOOK: begin
        state_next = S_DECIDE;
      end

      S_DECIDE: begin
        state_next    = S_FIN;
        status_q_next = ST_DONE;
        case (cmd_q)
          CMD_FETCH: begin
            if (!in_file_q) begin
              status_q_next = ST_NOT_PRESENT;
            end else if (hit_q) begin
              op.set_refs   = 1'b1;
              op.refs       = refs_inc;
              status_q_next = ST_HIT;
            end else if (!ok_q) begin
              status_q_next = ST_LOAD_ERR;
            end else if (!free_any) begin
              status_q_next = ST_NO_ROOM;
            end else begin
              op_idx        = free_idx;
              op.ins        = 1'b1;
              op.size       = size_in_q;
              op.pri        = NORM_PRI;
              op.refs       = 8'd1;
              op.stamp      = clock_q;
              bytes_q_next  = bytes_ins;
              status_q_next = ST_LOADED;
              if (bytes_ins > limit_q) begin
                need_q_next     = $signed(NEED_W'(bytes_ins)) - $signed(NEED_W'(limit_q));
                pri_last_q_next = PRI_ALL;
                cnt_next        = '0;
                state_next      = S_SCAN;
              end
            end
          end
          CMD_PREFETCH: begin
            if (!in_file_q) begin
              status_q_next = ST_NOT_PRESENT;
            end else if (hit_q) begin
              op.set_pri    = 1'b1;
              op.pri        = pf_pri;
              op.set_stamp  = 1'b1;
              op.stamp      = clock_q;
              clock_q_next  = clock_q + 32'd1;
              status_q_next = ST_HIT;
              if ((refs_q == 8'd0) && ((pf_pri == 3'd0) || over_now)) begin
                ev_size_q_next = hsize_q;
                state_next     = S_EV_ADDR;
              end
            end else if (!ok_q) begin
              status_q_next = ST_LOAD_ERR;
            end else begin
              status_q_next = ST_LOADED;
              if (sum_ins > (BYTES_W+1)'(limit_q)) begin
                if (req_q == 3'd0) begin
                  status_q_next = ST_NO_ROOM;
                end else begin
                  need_q_next     = $signed(NEED_W'(sum_ins)) - $signed(NEED_W'(limit_q));
                  pri_last_q_next = req_q - 3'd1;
                  cnt_next        = '0;
                  state_next      = S_SCAN;
                end
              end else begin
                state_next = S_PF_INS;
              end
            end
          end
          CMD_FIND: begin
            if (!hit_q || !in_file_q) begin
              status_q_next = ST_NOT_CACHED;
            end else begin
              op.set_refs   = 1'b1;
              op.refs       = refs_inc;
              status_q_next = ST_HIT;
            end
          end
          CMD_SETPRI: begin
            if (!hit_q || !in_file_q) begin
              status_q_next = ST_NOT_CACHED;
            end else begin
              op.set_pri = 1'b1;
              op.pri     = req_q;
              if (refs_q == 8'd0) begin
                op.set_stamp = 1'b1;
                op.stamp     = clock_q;
                clock_q_next = clock_q + 32'd1;
                if ((req_q == 3'd0) || over_now) begin
                  ev_size_q_next = hsize_q;
                  state_next     = S_EV_ADDR;
                end
              end
            end
          end
          CMD_RELEASE: begin
            if (!hit_q) begin
              status_q_next = ST_NOT_CACHED;
            end else if (refs_q != 8'd0) begin
              op.set_refs = 1'b1;
              op.refs     = refs_q - 8'd1;
              if (refs_q == 8'd1) begin
                op.set_stamp = 1'b1;
                op.stamp     = clock_q;
                clock_q_next = clock_q + 32'd1;
                if ((pri_q == 3'd0) || over_now) begin
                  ev_size_q_next = hsize_q;
                  state_next     = S_EV_ADDR;
                end
              end
            end
          end
          CMD_TRIM: begin
            if (over_now) begin
              need_q_next     = $signed(NEED_W'(bytes_q)) - $signed(NEED_W'(limit_q));
              pri_last_q_next = PRI_ALL;
              cnt_next        = '0;
              state_next      = S_SCAN;
            end
          end
          default: begin
            status_q_next = ST_DONE;
          end
        endcase
      end

      // walk the chain until the last stage holds the victim
      S_SCAN: begin
        cnt_next = cnt + CW'(1);
        if (cnt == CNT_END) begin
          if (!chain[ENTRIES].valid) begin
            if (cmd_q == CMD_PREFETCH) begin
              status_q_next = ST_NO_ROOM;
            end
            state_next = S_FIN;
          end else begin
            vic_q_next = chain[ENTRIES];
            state_next = S_EVICT;
          end
        end
      end

      S_EVICT: begin
        if (out_free) begin
          emit         = 1'b1;
          e_kind       = KIND_EVICT;
          e_key        = vic_q.key;
          e_bytes      = bytes_vic;
          op.clr       = 1'b1;
          op.key       = vic_q.key;
          bytes_q_next = bytes_vic;
          if (need_left <= 0) begin
            state_next = (cmd_q == CMD_PREFETCH) ? S_PF_INS : S_FIN;
          end else begin
            need_q_next = need_left;
            cnt_next    = '0;
            state_next  = S_SCAN;
          end
        end
      end

      // prefetch insert followed by its release check
      S_PF_INS: begin
        state_next = S_FIN;
        if (!free_any) begin
          status_q_next = ST_NO_ROOM;
        end else begin
          op_idx       = free_idx;
          op.ins       = 1'b1;
          op.size      = size_in_q;
          op.pri       = req_q;
          op.refs      = 8'd0;
          op.stamp     = clock_q + 32'd1;
          clock_q_next = clock_q + 32'd2;
          bytes_q_next = bytes_ins;
          if ((req_q == 3'd0) || (bytes_ins > limit_q)) begin
            ev_size_q_next = size_in_q;
            state_next     = S_EV_ADDR;
          end
        end
      end

      S_EV_ADDR: begin
        if (out_free) begin
          emit         = 1'b1;
          e_kind       = KIND_EVICT;
          e_bytes      = bytes_addr;
          op.clr       = 1'b1;
          bytes_q_next = bytes_addr;
          state_next   = S_FIN;
        end
      end

      S_FIN: begin
        if (out_free) begin
          emit       = 1'b1;
          e_status   = status_q;
          e_refs     = l_hit ? l_refs : 8'd0;
          e_last     = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clock_q   <= '0;
      bytes_q   <= '0;
      limit_q   <= LIMIT_RESET;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state   <= state_next;
      clock_q <= clock_q_next;
      bytes_q <= bytes_q_next;
      cnt     <= cnt_next;
      if (psel && penable && pwrite && pready && (paddr[2] == REG_LIMIT)) begin
        limit_q <= pwdata[BYTES_W-1:0];
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    status_q   <= status_q_next;
    need_q     <= need_q_next;
    pri_last_q <= pri_last_q_next;
    ev_size_q  <= ev_size_q_next;
    vic_q      <= vic_q_next;
    if (in_valid && in_ready) begin
      cmd_q     <= command;
      key_q     <= '{type_tag: type_tag, chunk_number: chunk_number,
                     reader_id: reader_id};
      in_file_q <= chunk_in_file;
      size_in_q <= object_size;
      ok_q      <= reader_ok;
      req_q     <= priority_req;
    end
    if (state == S_LOOK) begin
      hit_q   <= l_hit;
      idx_q   <= l_idx;
      refs_q  <= l_refs;
      pri_q   <= l_pri;
      hsize_q <= l_size;
    end
    if (emit) begin
      kind             <= e_kind;
      status           <= e_status;
      out_type_tag     <= e_key.type_tag;
      out_chunk_number <= e_key.chunk_number;
      out_reader_id    <= e_key.reader_id;
      ref_count        <= e_refs;
      bytes_in_use     <= e_bytes;
      last             <= e_last;
    end
  end

  // configuration read
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LIMIT) ? {3'b0, limit_q} : 32'd0;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // keys are unique, so at most one cell matches
  a_hit_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(c_hit))
    else $error("more than one entry matches the key");

  // byte count only moves while a command is in progress
  a_bytes_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> (bytes_q == $past(bytes_q)))
    else $error("byte count changed while idle");

  // eviction notices never close a command
  a_notice_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_EVICT)) |-> !last)
    else $error("eviction notice flagged as last");

  // a victim always comes from the chain with a valid mark
  a_victim_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVICT) |-> vic_q.valid)
    else $error("eviction without a victim");
`endif

endmodule

`default_nettype wire
